>>> hw/rtl/cln_pkg.sv
// Shared types, codes and constants of the character LCD nibble sequencer.
package cln_pkg;

   // Request codes
   localparam logic [2:0] CMD_INIT   = 3'd0;
   localparam logic [2:0] CMD_BYTE   = 3'd1;
   localparam logic [2:0] CMD_DATA   = 3'd2;
   localparam logic [2:0] CMD_CLEAR  = 3'd3;
   localparam logic [2:0] CMD_CURSOR = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_ENABLE_HIGH = 2'd0;
   localparam logic [1:0] CSR_SETTLE      = 2'd1;
   localparam logic [1:0] CSR_CLEAR_WAIT  = 2'd2;
   localparam logic [1:0] CSR_POWERUP     = 2'd3;

   // Configuration reset values
   localparam logic [7:0]  RST_ENABLE_HIGH = 8'd1;
   localparam logic [9:0]  RST_SETTLE      = 10'd40;
   localparam logic [13:0] RST_CLEAR_WAIT  = 14'd2000;
   localparam logic [15:0] RST_POWERUP     = 16'd50000;

   // Controller command bytes and wake nibbles
   localparam logic [7:0] LCD_FUNC_SET = 8'h28;
   localparam logic [7:0] LCD_DISP_ON  = 8'h0C;
   localparam logic [7:0] LCD_ENTRY    = 8'h06;
   localparam logic [7:0] LCD_CLEAR    = 8'h01;
   localparam logic [3:0] WAKE_NIB     = 4'h3;
   localparam logic [3:0] FOUR_BIT_NIB = 4'h2;

   // Extra waits after the first two wake nibbles
   localparam logic [13:0] WAKE_WAIT1_US = 14'd5000;
   localparam logic [13:0] WAKE_WAIT2_US = 14'd150;

   // Last nibble index of an init run and of a byte run
   localparam logic [3:0] INIT_LAST_NIB = 4'd11;
   localparam logic [3:0] BYTE_LAST_NIB = 4'd1;

   // Job queue geometry
   localparam int unsigned QUEUE_DEPTH = 2;

   // One classified request
   typedef struct packed {
      logic       is_init;
      logic       rs;
      logic [7:0] byte_val;
      logic       clr_extra;
   } job_type;

   // One pin segment
   typedef struct packed {
      logic        rs_level;
      logic [3:0]  data_nibble;
      logic        enable_level;
      logic [15:0] duration_us;
      logic        last;
   } seg_type;

   // Nibble sequence of the init run: wake nibbles and the four-bit nibble, then four command bytes
   function automatic logic [3:0] init_nibble(input logic [3:0] idx);
      logic [3:0] nib;
      case (idx)
         4'd0, 4'd1, 4'd2: nib = WAKE_NIB;
         4'd3:             nib = FOUR_BIT_NIB;
         4'd4:             nib = LCD_FUNC_SET[7:4];
         4'd5:             nib = LCD_FUNC_SET[3:0];
         4'd6:             nib = LCD_DISP_ON[7:4];
         4'd7:             nib = LCD_DISP_ON[3:0];
         4'd8:             nib = LCD_ENTRY[7:4];
         4'd9:             nib = LCD_ENTRY[3:0];
         4'd10:            nib = LCD_CLEAR[7:4];
         4'd11:            nib = LCD_CLEAR[3:0];
         default:          nib = 4'h0;
      endcase
      return nib;
   endfunction

endpackage

>>> hw/rtl/cln_front.sv
// Front end: accepts requests and turns them into queued jobs.
module cln_front
   import cln_pkg::*;
(
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_byte_value,
   input  logic       req_row,
   input  logic [5:0] req_col,
   input  logic       queue_full,
   output logic       push,
   output job_type    push_job
);

   logic keep;

   // Stall only on a full queue; unused codes are taken and dropped
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full && keep;

   // Request decode
   always_comb begin
      keep               = 1'b1;
      push_job.is_init   = 1'b0;
      push_job.rs        = 1'b0;
      push_job.byte_val  = req_byte_value;
      push_job.clr_extra = 1'b0;
      unique case (req_cmd)
         CMD_INIT: begin
            push_job.is_init = 1'b1;
         end
         CMD_BYTE: begin
            push_job.rs = 1'b0;
         end
         CMD_DATA: begin
            push_job.rs = 1'b1;
         end
         CMD_CLEAR: begin
            push_job.byte_val  = LCD_CLEAR;
            push_job.clr_extra = 1'b1;
         end
         CMD_CURSOR: begin
            // set-address bit, row base 0x40 as bit 6, column below it
            push_job.byte_val = {1'b1, req_row, req_col};
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

endmodule

>>> hw/rtl/cln_fifo.sv
// Two-entry job queue between front and back end.
module cln_fifo
   import cln_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   job_type    slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'(QUEUE_DEPTH));
   assign head_job = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("job queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH)) else $error("job queue count overflow");

endmodule

>>> hw/rtl/cln_back.sv
// Back end: configuration registers and the segment sequencer with its output register.
module cln_back
   import cln_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data,
   input  job_type     head_job,
   input  logic        empty,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output seg_type     rsp_seg
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_POWER  = 3'b010,
      ST_NIBBLE = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   job_type     job_ff, job_in;
   logic [3:0]  idx_ff, idx_in;
   logic        phase_ff, phase_in;
   logic [3:0]  held_nibble_ff, held_nibble_in;
   logic        rsp_valid_ff, rsp_valid_in;
   seg_type     rsp_seg_ff, rsp_seg_in;

   logic [7:0]  enable_high_ff;
   logic [9:0]  settle_ff;
   logic [13:0] clear_wait_ff;
   logic [15:0] powerup_ff;

   logic        running, out_free, emit;
   job_type     cur_job;
   logic        cur_power, cur_phase;
   logic [3:0]  cur_idx, last_idx, cur_nib;
   logic [13:0] extra;
   seg_type     seg;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_seg   = rsp_seg_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_high_ff <= RST_ENABLE_HIGH;
         settle_ff      <= RST_SETTLE;
         clear_wait_ff  <= RST_CLEAR_WAIT;
         powerup_ff     <= RST_POWERUP;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLE_HIGH: enable_high_ff <= csr_wr_data[7:0];
            CSR_SETTLE:      settle_ff      <= csr_wr_data[9:0];
            CSR_CLEAR_WAIT:  clear_wait_ff  <= csr_wr_data[13:0];
            CSR_POWERUP:     powerup_ff     <= csr_wr_data;
         endcase
      end
   end

   // Current job and position: the running job, or the queue head at its start
   always_comb begin
      running  = (state_ff != ST_IDLE);
      out_free = !rsp_valid_ff || !rsp_stall;
      emit     = out_free && (running || !empty);
      pop      = out_free && !running && !empty;
      if (running) begin
         cur_job   = job_ff;
         cur_power = (state_ff == ST_POWER);
         cur_idx   = idx_ff;
         cur_phase = phase_ff;
      end else begin
         cur_job   = head_job;
         cur_power = head_job.is_init;
         cur_idx   = 4'd0;
         cur_phase = 1'b0;
      end
   end

   // Segment build
   always_comb begin
      if (cur_job.is_init) begin
         cur_nib = init_nibble(cur_idx);
      end else begin
         cur_nib = cur_idx[0] ? cur_job.byte_val[3:0] : cur_job.byte_val[7:4];
      end
      last_idx = cur_job.is_init ? INIT_LAST_NIB : BYTE_LAST_NIB;

      // extra settle time after particular nibbles
      extra = 14'd0;
      if (cur_job.is_init) begin
         if (cur_idx == 4'd0) begin
            extra = WAKE_WAIT1_US;
         end else if (cur_idx == 4'd1) begin
            extra = WAKE_WAIT2_US;
         end else if (cur_idx == INIT_LAST_NIB) begin
            extra = clear_wait_ff;
         end
      end else if (cur_job.clr_extra && cur_idx == BYTE_LAST_NIB) begin
         extra = clear_wait_ff;
      end

      if (cur_power) begin
         seg.rs_level     = 1'b0;
         seg.data_nibble  = held_nibble_ff;
         seg.enable_level = 1'b0;
         seg.duration_us  = powerup_ff;
         seg.last         = 1'b0;
      end else begin
         seg.rs_level     = cur_job.is_init ? 1'b0 : cur_job.rs;
         seg.data_nibble  = cur_nib;
         seg.enable_level = !cur_phase;
         seg.duration_us  = cur_phase ? ({6'd0, settle_ff} + {2'd0, extra})
                                      : {8'd0, enable_high_ff};
         seg.last         = cur_phase && (cur_idx == last_idx);
      end
   end

   // Sequencer advance
   always_comb begin
      state_in       = state_ff;
      job_in         = job_ff;
      idx_in         = idx_ff;
      phase_in       = phase_ff;
      held_nibble_in = held_nibble_ff;
      if (emit) begin
         job_in         = cur_job;
         held_nibble_in = seg.data_nibble;
         if (cur_power) begin
            state_in = ST_NIBBLE;
            idx_in   = 4'd0;
            phase_in = 1'b0;
         end else if (seg.last) begin
            state_in = ST_IDLE;
         end else if (!cur_phase) begin
            state_in = ST_NIBBLE;
            idx_in   = cur_idx;
            phase_in = 1'b1;
         end else begin
            state_in = ST_NIBBLE;
            idx_in   = cur_idx + 4'd1;
            phase_in = 1'b0;
         end
      end
   end

   // Output register takes a new segment whenever it is free
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_seg_in   = rsp_seg_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         rsp_seg_in   = seg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= 4'd0;
         phase_ff       <= 1'b0;
         held_nibble_ff <= 4'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         phase_ff       <= phase_in;
         held_nibble_ff <= held_nibble_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      rsp_seg_ff <= rsp_seg_in;
   end

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NIBBLE) |-> (idx_ff <= (job_ff.is_init ? INIT_LAST_NIB : BYTE_LAST_NIB)))
      else $error("nibble index past end of run");

   a_power_then_pulse: assert property (@(posedge clock) disable iff (reset)
      (emit && cur_power) |=> (state_ff == ST_NIBBLE && idx_ff == 4'd0 && !phase_ff))
      else $error("power-up segment not followed by first wake pulse");

   a_pop_starts_job: assert property (@(posedge clock) disable iff (reset)
      pop |-> (emit && !running)) else $error("job taken without a segment");

   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      (emit && seg.last) |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after last segment");

endmodule

>>> hw/rtl/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer (4-bit bus controller).
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   cmd, byte_value, row, col
//   rsp       out        rsp_valid/rsp_stall   rs_level, data_nibble, enable_level,
//                                              duration_us, last
//   csr       in         csr_wr_en             csr_index, csr_wr_data
//
// One segment leaves per cycle while rsp_stall is low: a byte request gives 4 segments, init 25,
// clear and set cursor 4; unused codes are taken and give nothing.
// The sequencer emits one segment per cycle from its output register while that register is free,
// and picks up the next queued job once its state is back to idle after a last segment, so requests run back to back.
// A two-entry job queue parts the request side from the sequencer.
// Reset is synchronous and clears the queue, the sequencer and the registers.
// req_stall is high only while the queue is full; rsp_stall holds the output register.
module char_lcd_nibble_sequencer
   import cln_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_byte_value,
   input  logic        req_row,
   input  logic [5:0]  req_col,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_rs_level,
   output logic [3:0]  rsp_data_nibble,
   output logic        rsp_enable_level,
   output logic [15:0] rsp_duration_us,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   logic    push, pop, empty, full;
   job_type push_job, head_job;
   seg_type rsp_seg;

   cln_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_col        (req_col),
      .queue_full     (full),
      .push           (push),
      .push_job       (push_job)
   );

   cln_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty),
      .full     (full)
   );

   cln_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .head_job    (head_job),
      .empty       (empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_seg     (rsp_seg)
   );

   // Segment fields out to their ports
   assign rsp_rs_level     = rsp_seg.rs_level;
   assign rsp_data_nibble  = rsp_seg.data_nibble;
   assign rsp_enable_level = rsp_seg.enable_level;
   assign rsp_duration_us  = rsp_seg.duration_us;
   assign rsp_last         = rsp_seg.last;

endmodule

>>> dv/tb_char_lcd_nibble_sequencer.sv
// Self-checking testbench for the character LCD nibble sequencer.
module tb_char_lcd_nibble_sequencer;
   import cln_pkg::*;

   // Codes the block ignores, and cursor address constants
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam logic [7:0] LCD_SET_ADDR = 8'h80;
   localparam logic [7:0] ROW1_BASE    = 8'h40;

   localparam int DRAIN_SETTLE = 20;
   localparam int IDLE_LIMIT   = 2000;
   localparam int MAX_REPORTS  = 10;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
   } stall_mode_type;

   // Predicts the pin segments of each request and checks them in order
   class lcd_segment_scoreboard;
      seg_type     expected_segments[$];
      logic [7:0]  enable_high;
      logic [9:0]  settle;
      logic [13:0] clear_wait;
      logic [15:0] powerup;
      logic        held_rs;
      logic [3:0]  held_nibble;
      int          mismatches;

      function new();
         enable_high = RST_ENABLE_HIGH;
         settle      = RST_SETTLE;
         clear_wait  = RST_CLEAR_WAIT;
         powerup     = RST_POWERUP;
         held_rs     = 1'b0;
         held_nibble = 4'h0;
         mismatches  = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] value);
         case (idx)
            CSR_ENABLE_HIGH: enable_high = value[7:0];
            CSR_SETTLE:      settle      = value[9:0];
            CSR_CLEAR_WAIT:  clear_wait  = value[13:0];
            CSR_POWERUP:     powerup     = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_segments.size();
      endfunction

      function void push_seg(logic rs, logic [3:0] nib, logic en, int unsigned dur);
         seg_type s;
         s.rs_level     = rs;
         s.data_nibble  = nib;
         s.enable_level = en;
         s.duration_us  = (dur > 32'hFFFF) ? 16'hFFFF : dur[15:0];
         s.last         = 1'b0;
         expected_segments.push_back(s);
         held_rs     = rs;
         held_nibble = nib;
      endfunction

      // Enable-high pulse, then the low settle with any extra wait folded in
      function void push_nibble(logic rs, logic [3:0] nib, int unsigned extra);
         push_seg(rs, nib, 1'b1, 32'(enable_high));
         push_seg(rs, nib, 1'b0, 32'(settle) + extra);
      endfunction

      function void push_byte(logic rs, logic [7:0] b, int unsigned extra);
         push_nibble(rs, b[7:4], 0);
         push_nibble(rs, b[3:0], extra);
      endfunction

      function void predict_segments(logic [2:0] cmd, logic [7:0] b, logic row,
                                     logic [5:0] col);
         int         first;
         logic [7:0] addr;
         seg_type    tail;
         first = expected_segments.size();
         addr  = row ? ROW1_BASE + {2'b00, col} : {2'b00, col};
         case (cmd)
            CMD_INIT: begin
               push_seg(1'b0, held_nibble, 1'b0, 32'(powerup));
               push_nibble(1'b0, WAKE_NIB, 32'(WAKE_WAIT1_US));
               push_nibble(1'b0, WAKE_NIB, 32'(WAKE_WAIT2_US));
               push_nibble(1'b0, WAKE_NIB, 0);
               push_nibble(1'b0, FOUR_BIT_NIB, 0);
               push_byte(1'b0, LCD_FUNC_SET, 0);
               push_byte(1'b0, LCD_DISP_ON, 0);
               push_byte(1'b0, LCD_ENTRY, 0);
               push_byte(1'b0, LCD_CLEAR, 32'(clear_wait));
            end
            CMD_BYTE:   push_byte(1'b0, b, 0);
            CMD_DATA:   push_byte(1'b1, b, 0);
            CMD_CLEAR:  push_byte(1'b0, LCD_CLEAR, 32'(clear_wait));
            CMD_CURSOR: push_byte(1'b0, LCD_SET_ADDR | addr, 0);
            default: ;
         endcase
         if (expected_segments.size() > first) begin
            tail      = expected_segments.pop_back();
            tail.last = 1'b1;
            expected_segments.push_back(tail);
         end
      endfunction

      function void check_segment(logic rs, logic [3:0] nib, logic en, logic [15:0] dur,
                                  logic lst);
         seg_type exp;
         if (expected_segments.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected segment: rs %0d nib %h en %0d dur %0d last %0d",
                        rs, nib, en, dur, lst);
            return;
         end
         exp = expected_segments.pop_front();
         if (exp.rs_level !== rs || exp.data_nibble !== nib || exp.enable_level !== en ||
             exp.duration_us !== dur || exp.last !== lst) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("segment mismatch: exp rs %0d nib %h en %0d dur %0d last %0d",
                        exp.rs_level, exp.data_nibble, exp.enable_level, exp.duration_us,
                        exp.last);
               $display("                  got rs %0d nib %h en %0d dur %0d last %0d",
                        rs, nib, en, dur, lst);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = CMD_INIT;
   logic [7:0]  req_byte_value = 8'h00;
   logic        req_row = 1'b0;
   logic [5:0]  req_col = 6'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_rs_level;
   logic [3:0]  rsp_data_nibble;
   logic        rsp_enable_level;
   logic [15:0] rsp_duration_us;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_ENABLE_HIGH;
   logic [15:0] csr_wr_data = 16'h0000;

   lcd_segment_scoreboard sb = new();

   char_lcd_nibble_sequencer DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Check every accepted segment
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_segment(rsp_rs_level, rsp_data_nibble, rsp_enable_level, rsp_duration_us,
                          rsp_last);
   end

   // Receiver stall pattern: four stall modes, switched at random
   stall_mode_type stall_mode = STALL_NONE;
   int          mode_left = 64;
   logic [2:0]  stall_phase = 3'd0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 3'd1;
      if (mode_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(32, 256);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
         STALL_PERIODIC: rsp_stall <= (stall_phase < 3'd3);
         default:        rsp_stall <= 1'b0;
      endcase
   end

   // Watchdog on cycles without any accepted item
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_char_lcd_nibble_sequencer NOT OK");
            $finish;
         end
      end
   end

   // Present one request and hold it until accepted; valid stays high afterward
   task automatic push_request(input logic [2:0] cmd, input logic [7:0] b, input logic row,
                               input logic [5:0] col);
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_byte_value <= b;
      req_row        <= row;
      req_col        <= col;
      do @(posedge clock); while (req_stall);
      sb.predict_segments(cmd, b, row, col);
   endtask

   // Sender holds off until every expected segment is out, then lets the block settle
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic write_config(input logic [15:0] en_us, input logic [15:0] settle_us,
                               input logic [15:0] clear_us, input logic [15:0] powerup_us);
      csr_write(CSR_ENABLE_HIGH, en_us);
      csr_write(CSR_SETTLE, settle_us);
      csr_write(CSR_CLEAR_WAIT, clear_us);
      csr_write(CSR_POWERUP, powerup_us);
      csr_wr_en <= 1'b0;
   endtask

   // Field extremes, every request, cursor corners, ignored codes, init after held pins
   task automatic run_directed();
      push_request(CMD_INIT, 8'h00, 1'b0, 6'd0);
      push_request(CMD_BYTE, 8'h00, 1'b0, 6'd0);
      push_request(CMD_BYTE, 8'hFF, 1'b1, 6'd63);
      push_request(CMD_DATA, 8'h00, 1'b0, 6'd0);
      push_request(CMD_DATA, 8'hFF, 1'b1, 6'd63);
      push_request(CMD_INIT, 8'hFF, 1'b1, 6'd63);
      push_request(CMD_DATA, 8'hA5, 1'b0, 6'd21);
      push_request(CMD_BYTE, 8'h5A, 1'b1, 6'd42);
      push_request(CMD_CLEAR, 8'hFF, 1'b1, 6'd63);
      push_request(CMD_CURSOR, 8'h00, 1'b0, 6'd0);
      push_request(CMD_CURSOR, 8'hFF, 1'b0, 6'd63);
      push_request(CMD_CURSOR, 8'h00, 1'b1, 6'd0);
      push_request(CMD_CURSOR, 8'hFF, 1'b1, 6'd63);
      push_request(CMD_SPARE_LO, 8'hFF, 1'b1, 6'd63);
      push_request(CMD_SPARE_LO + 3'd1, 8'h00, 1'b0, 6'd0);
      push_request(CMD_SPARE_HI, 8'h5A, 1'b1, 6'd21);
      // ignored code between a data byte and init leaves the held nibble in place
      push_request(CMD_DATA, 8'h36, 1'b0, 6'd5);
      push_request(CMD_SPARE_HI, 8'hC3, 1'b0, 6'd9);
      push_request(CMD_INIT, 8'h00, 1'b0, 6'd0);
      push_request(CMD_CURSOR, 8'h00, 1'b1, 6'd33);
   endtask

   // Random requests in bursts with random gaps; ignored codes do not count
   task automatic run_random(input int count);
      int         done;
      int         burst;
      int         gap;
      int         pick;
      logic [2:0] cmd;
      done = 0;
      while (done < count) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            pick = $urandom_range(0, 99);
            if (pick < 6)       cmd = CMD_INIT;
            else if (pick < 31) cmd = CMD_BYTE;
            else if (pick < 61) cmd = CMD_DATA;
            else if (pick < 71) cmd = CMD_CLEAR;
            else if (pick < 92) cmd = CMD_CURSOR;
            else                cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            push_request(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         6'($urandom_range(0, 63)));
            if (cmd <= CMD_CURSOR)
               done++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings
      run_directed();
      wait_for_drain();

      // zero-length pulses and settles, no clear wait
      write_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_request(CMD_INIT, 8'h00, 1'b0, 6'd0);
      run_random(60);
      wait_for_drain();

      // all ones: upper bits beyond each register width are dropped
      write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_request(CMD_INIT, 8'h00, 1'b0, 6'd0);
      push_request(CMD_CLEAR, 8'h00, 1'b0, 6'd0);
      run_random(60);
      wait_for_drain();

      // in-range corners
      write_config(16'd1, 16'd1, 16'd0, 16'd60000);
      run_random(60);
      wait_for_drain();

      repeat (3) begin
         write_config(16'($urandom()), 16'($urandom_range(1, 1023)),
                      16'($urandom_range(0, 16383)), 16'($urandom_range(0, 60000)));
         run_random(45);
         wait_for_drain();
      end

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb_char_lcd_nibble_sequencer OK");
      end else begin
         $display("tb_char_lcd_nibble_sequencer NOT OK");
      end
      $finish;
   end

endmodule
